### rtl/urc_pkg.sv
package urc_pkg;

   // Fixed field widths
   localparam int DIST_W     = 11;
   localparam int DIGIT_W    = 4;
   localparam int TIMEOUT_W  = 16;
   localparam int TRIGGER_W  = 8;
   localparam int SCALE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = {DIGIT_W{1'b1}};

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 2'd2;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd10000;
   localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 8'd10;
   localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd1219;

   // Reciprocal multipliers for the decimal split (exact for 11-bit values)
   localparam logic [12:0] RECIP_100 = 13'd5243;  // 2^19 / 100, rounded up
   localparam logic [12:0] RECIP_10  = 13'd6554;  // 2^16 / 10, rounded up

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_WAIT = 2'd2,
      PH_MEAS = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [TRIGGER_W-1:0] trigger_ticks;
      logic [SCALE_W-1:0]   scale_q16;
   } cfg_type;

   // Per-request flags leaving the sequencer stage
   typedef struct packed {
      logic trig;
      logic busy;
      logic done;
      logic finish;
      logic timeout;
   } seq_flags_type;

   // Per-request flags leaving the scaling stage
   typedef struct packed {
      logic trig;
      logic busy;
      logic done;
   } scl_flags_type;

   typedef struct packed {
      logic               trigger_out;
      logic               busy_res;
      logic               done_res;
      logic               fault;
      logic [DIST_W-1:0]  distance_cm;
      logic [DIGIT_W-1:0] digit_hundreds;
      logic [DIGIT_W-1:0] digit_tens;
      logic [DIGIT_W-1:0] digit_units;
   } rsp_type;

endpackage

### rtl/urc_if.sv
interface urc_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo_level;

   modport source (output valid, output start_req, output echo_level, input ready);
   modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface urc_rsp_if import urc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               trigger_out;
   logic               busy_res;
   logic               done_res;
   logic               fault;
   logic [DIST_W-1:0]  distance_cm;
   logic [DIGIT_W-1:0] digit_hundreds;
   logic [DIGIT_W-1:0] digit_tens;
   logic [DIGIT_W-1:0] digit_units;

   modport source (output valid, output trigger_out, output busy_res, output done_res,
                   output fault, output distance_cm, output digit_hundreds,
                   output digit_tens, output digit_units, input ready);
   modport sink (input valid, input trigger_out, input busy_res, input done_res,
                 input fault, input distance_cm, input digit_hundreds,
                 input digit_tens, input digit_units, output ready);
endinterface

interface urc_csr_if import urc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/urc_csr.sv
module urc_csr import urc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_TIMEOUT: cfg_in.timeout_ticks = wr_data[TIMEOUT_W-1:0];
            CSR_TRIGGER: cfg_in.trigger_ticks = wr_data[TRIGGER_W-1:0];
            CSR_SCALE:   cfg_in.scale_q16     = wr_data[SCALE_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
         cfg_ff.trigger_ticks <= TRIGGER_RST;
         cfg_ff.scale_q16     <= SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/urc_seq.sv
module urc_seq import urc_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      stage_ready,
   input  logic                      req_valid,
   input  logic                      start_req,
   input  logic                      echo_level,
   output logic                      out_valid,
   output seq_flags_type             out_flags,
   output logic [COUNT_WIDTH+15:0]   out_product
);

   localparam int PROD_W = COUNT_WIDTH + SCALE_W;
   localparam int CMP_W  = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   phase_type               phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    valid_ff, valid_in;
   seq_flags_type           flags_ff, flags_in;
   logic [PROD_W-1:0]       product_ff, product_in;

   logic                    accept;
   logic [COUNT_WIDTH-1:0]  count_inc;
   logic [CMP_W-1:0]        ttk_ext;
   logic [CMP_W-1:0]        tmo_ext;
   logic [CMP_W-1:0]        inc_ext;

   assign accept    = req_valid && stage_ready;
   assign count_inc = (count_ff == CNT_MAX) ? count_ff : count_ff + CNT_ONE;
   assign inc_ext   = CMP_W'(count_inc);

   // A zero in either tick register behaves as one.
   assign ttk_ext = (cfg.trigger_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.trigger_ticks);
   assign tmo_ext = (cfg.timeout_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.timeout_ticks);

   // Measurement sequencer: next phase, tick counter and per-request flags.
   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      flags_in       = '0;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (start_req) begin
                  flags_in.trig = 1'b1;
                  if (ttk_ext == CMP_W'(1)) begin
                     phase_in = PH_WAIT;
                     count_in = '0;
                  end else begin
                     phase_in = PH_TRIG;
                     count_in = CNT_ONE;
                  end
               end
            end
            PH_TRIG: begin
               flags_in.trig = 1'b1;
               count_in      = count_inc;
               if (inc_ext >= ttk_ext) begin
                  phase_in = PH_WAIT;
                  count_in = '0;
               end
            end
            PH_WAIT: begin
               if (echo_level) begin
                  phase_in = PH_MEAS;
                  count_in = CNT_ONE;
               end else begin
                  count_in = count_inc;
                  if (inc_ext >= tmo_ext || count_inc == CNT_MAX) begin
                     phase_in         = PH_IDLE;
                     count_in         = '0;
                     flags_in.done    = 1'b1;
                     flags_in.timeout = 1'b1;
                  end
               end
            end
            PH_MEAS: begin
               if (echo_level) begin
                  count_in = count_inc;
               end else begin
                  phase_in        = PH_IDLE;
                  count_in        = '0;
                  flags_in.done   = 1'b1;
                  flags_in.finish = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         endcase
         flags_in.busy = (phase_in != PH_IDLE);
      end
   end

   // Echo width times the scale; the shift happens in the next stage.
   assign product_in = PROD_W'(count_ff) * PROD_W'(cfg.scale_q16);

   assign valid_in = stage_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff   <= flags_in;
         product_ff <= product_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_flags   = flags_ff;
   assign out_product = product_ff;

endmodule

### rtl/urc_scale.sv
module urc_scale import urc_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    stage_ready,
   input  logic                    in_valid,
   input  seq_flags_type           in_flags,
   input  logic [COUNT_WIDTH+15:0] in_product,
   output logic                    out_valid,
   output scl_flags_type           out_flags,
   output logic                    last_fault,
   output logic [DIST_W-1:0]       last_distance
);

   logic                   valid_ff, valid_in;
   scl_flags_type          flags_ff;
   logic                   fault_ff, fault_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic [COUNT_WIDTH-1:0] dist_full;
   logic [DIST_W-1:0]      dist_sat;
   logic                   load;

   assign load = in_valid && stage_ready;

   // Drop the Q16 fraction and clamp to the distance field.
   assign dist_full = in_product[COUNT_WIDTH+15:SCALE_W];
   assign dist_sat  = (dist_full > COUNT_WIDTH'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];

   // The last result only changes when a measurement ends.
   always_comb begin
      dist_in  = dist_ff;
      fault_in = fault_ff;
      if (load) begin
         if (in_flags.finish) begin
            dist_in  = dist_sat;
            fault_in = (dist_sat == '0);
         end else if (in_flags.timeout) begin
            dist_in  = '0;
            fault_in = 1'b1;
         end
      end
   end

   assign valid_in = stage_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dist_ff  <= '0;
         fault_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         dist_ff  <= dist_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff.trig <= in_flags.trig;
         flags_ff.busy <= in_flags.busy;
         flags_ff.done <= in_flags.done;
      end
   end

   assign out_valid     = valid_ff;
   assign out_flags     = flags_ff;
   assign last_fault    = fault_ff;
   assign last_distance = dist_ff;

endmodule

### rtl/urc_digits.sv
module urc_digits import urc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              stage_ready,
   input  logic              in_valid,
   input  scl_flags_type     in_flags,
   input  logic              in_fault,
   input  logic [DIST_W-1:0] in_distance,
   output logic              out_valid,
   output rsp_type           out_rsp
);

   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [23:0] hund_prod;
   logic [23:0] ten_prod;
   logic [4:0]  hund;
   logic [7:0]  q10;
   logic [7:0]  tens_full;
   logic [DIST_W-1:0] units_full;

   // Divide by 100 and by 10 through reciprocal multipliers.
   assign hund_prod = 24'(in_distance) * 24'(RECIP_100);
   assign ten_prod  = 24'(in_distance) * 24'(RECIP_10);
   assign hund      = hund_prod[23:19];
   assign q10       = ten_prod[23:16];

   // Remainders by subtracting the scaled quotients.
   assign tens_full  = q10 - ((8'(hund) << 3) + (8'(hund) << 1));
   assign units_full = in_distance - ((DIST_W'(q10) << 3) + (DIST_W'(q10) << 1));

   always_comb begin
      rsp_in.trigger_out    = in_flags.trig;
      rsp_in.busy_res       = in_flags.busy;
      rsp_in.done_res       = in_flags.done;
      rsp_in.fault          = in_fault;
      rsp_in.distance_cm    = in_distance;
      rsp_in.digit_hundreds = (hund > 5'(DIGIT_MAX)) ? DIGIT_MAX : hund[DIGIT_W-1:0];
      rsp_in.digit_tens     = tens_full[DIGIT_W-1:0];
      rsp_in.digit_units    = units_full[DIGIT_W-1:0];
   end

   assign valid_in = stage_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && stage_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

### rtl/ultrasonic_ranging_controller_core.sv
// Channel   Dir   Handshake      Payload
// req_chan  in    valid/ready    start_req, echo_level (one timer tick)
// rsp_chan  out   valid/ready    trigger_out, busy_res, done_res, fault, distance_cm, digits
// csr_chan  in    valid/ready    index, data (register write)
//
// One request per cycle while responses are taken; each yields one response through the
// stages sequencer with multiplier, scale and clamp, decimal split with output register.
// Reset clears the sequencer, the last result and all stage valids; registers take defaults.
// Each stage moves when the one after it is empty or moving, so up to two more requests
// are taken while a response waits before the request side stalls. Register writes are
// always accepted.
module ultrasonic_ranging_controller_core import urc_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   urc_req_if.sink   req_chan,
   urc_rsp_if.source rsp_chan,
   urc_csr_if.sink   csr_chan
);

   cfg_type                 cfg;
   logic                    seq_valid;
   seq_flags_type           seq_flags;
   logic [COUNT_WIDTH+15:0] seq_product;
   logic                    scl_valid;
   scl_flags_type           scl_flags;
   logic                    scl_fault;
   logic [DIST_W-1:0]       scl_distance;
   logic                    dig_valid;
   rsp_type                 dig_rsp;
   logic                    dig_ready;
   logic                    scl_ready;
   logic                    seq_ready;

   // Stage advance chain from the response side back to the request side.
   assign dig_ready = !dig_valid || rsp_chan.ready;
   assign scl_ready = !scl_valid || dig_ready;
   assign seq_ready = !seq_valid || scl_ready;

   assign req_chan.ready = seq_ready;
   assign csr_chan.ready = 1'b1;

   urc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   urc_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_ready (seq_ready),
      .req_valid   (req_chan.valid),
      .start_req   (req_chan.start_req),
      .echo_level  (req_chan.echo_level),
      .out_valid   (seq_valid),
      .out_flags   (seq_flags),
      .out_product (seq_product)
   );

   urc_scale #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .stage_ready   (scl_ready),
      .in_valid      (seq_valid),
      .in_flags      (seq_flags),
      .in_product    (seq_product),
      .out_valid     (scl_valid),
      .out_flags     (scl_flags),
      .last_fault    (scl_fault),
      .last_distance (scl_distance)
   );

   urc_digits u_digits (
      .clock       (clock),
      .reset       (reset),
      .stage_ready (dig_ready),
      .in_valid    (scl_valid),
      .in_flags    (scl_flags),
      .in_fault    (scl_fault),
      .in_distance (scl_distance),
      .out_valid   (dig_valid),
      .out_rsp     (dig_rsp)
   );

   assign rsp_chan.valid          = dig_valid;
   assign rsp_chan.trigger_out    = dig_rsp.trigger_out;
   assign rsp_chan.busy_res       = dig_rsp.busy_res;
   assign rsp_chan.done_res       = dig_rsp.done_res;
   assign rsp_chan.fault          = dig_rsp.fault;
   assign rsp_chan.distance_cm    = dig_rsp.distance_cm;
   assign rsp_chan.digit_hundreds = dig_rsp.digit_hundreds;
   assign rsp_chan.digit_tens     = dig_rsp.digit_tens;
   assign rsp_chan.digit_units    = dig_rsp.digit_units;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import urc_pkg::*;

   localparam int COUNT_WIDTH = 16;
   localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1300;
   localparam int MAX_PRINTED = 50;

   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;

   // One row of the directed plan: either a timer tick or a register write.
   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      bit                    start;
      bit                    echo;
      bit                    known;
      rsp_type               reading;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urc_req_if req_chan ();
   urc_rsp_if rsp_chan ();
   urc_csr_if csr_chan ();

   ultrasonic_ranging_controller_core #(.COUNT_WIDTH(COUNT_WIDTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Ranging predictor state and its copy of the registers.
   cfg_type            ranger_cfg;
   phase_type          ranger_phase;
   int unsigned        ranger_ticks;
   logic [DIST_W-1:0]  ranger_distance;
   logic               ranger_fault;

   rsp_type     readings_due[$];
   row_type     plan[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          rsp_hold = 0;
   bit          req_up = 1'b0;
   bit          no_gaps = 1'b0;
   int unsigned ticks_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned bump(input int unsigned count);
      return (count >= COUNT_MAX) ? COUNT_MAX : count + 1;
   endfunction

   // Advance the ranging sequencer by one timer tick and return the reading it shows.
   function automatic rsp_type next_reading(input bit start, input bit echo);
      rsp_type         r;
      int unsigned     trig_len;
      int unsigned     wait_len;
      longint unsigned scaled;
      int unsigned     hundreds;
      logic            trig;
      logic            done;

      trig = 1'b0;
      done = 1'b0;
      trig_len = (ranger_cfg.trigger_ticks == 0) ? 1 : ranger_cfg.trigger_ticks;
      wait_len = (ranger_cfg.timeout_ticks == 0) ? 1 : ranger_cfg.timeout_ticks;
      case (ranger_phase)
         PH_IDLE: begin
            if (start) begin
               trig = 1'b1;
               ranger_ticks = 1;
               if (ranger_ticks >= trig_len) begin
                  ranger_phase = PH_WAIT;
                  ranger_ticks = 0;
               end else begin
                  ranger_phase = PH_TRIG;
               end
            end
         end
         PH_TRIG: begin
            trig = 1'b1;
            ranger_ticks = bump(ranger_ticks);
            if (ranger_ticks >= trig_len) begin
               ranger_phase = PH_WAIT;
               ranger_ticks = 0;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               ranger_phase = PH_MEAS;
               ranger_ticks = 1;
            end else begin
               ranger_ticks = bump(ranger_ticks);
               // No echo in time, or the wait counter ran out: sensor fault.
               if (ranger_ticks >= wait_len || ranger_ticks >= COUNT_MAX) begin
                  ranger_distance = '0;
                  ranger_fault = 1'b1;
                  ranger_phase = PH_IDLE;
                  ranger_ticks = 0;
                  done = 1'b1;
               end
            end
         end
         default: begin
            if (echo) begin
               ranger_ticks = bump(ranger_ticks);
            end else begin
               // Echo fell: scale the pulse width, clamp, flag a zero distance.
               scaled = (longint'(ranger_ticks) * ranger_cfg.scale_q16) >> 16;
               if (scaled > DIST_MAX) scaled = DIST_MAX;
               ranger_distance = scaled[DIST_W-1:0];
               ranger_fault = (scaled == 0);
               ranger_phase = PH_IDLE;
               ranger_ticks = 0;
               done = 1'b1;
            end
         end
      endcase

      hundreds = ranger_distance / 100;
      if (hundreds > DIGIT_MAX) hundreds = DIGIT_MAX;
      r.trigger_out    = trig;
      r.busy_res       = (ranger_phase != PH_IDLE);
      r.done_res       = done;
      r.fault          = ranger_fault;
      r.distance_cm    = ranger_distance;
      r.digit_hundreds = hundreds[DIGIT_W-1:0];
      r.digit_tens     = DIGIT_W'((ranger_distance / 10) % 10);
      r.digit_units    = DIGIT_W'(ranger_distance % 10);
      return r;
   endfunction

   task automatic report(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
   endtask

   // Compare one response with the oldest pending reading, field by field.
   task automatic check_reading(input rsp_type got);
      rsp_type want;
      if (readings_due.size() == 0) begin
         report("unexpected response", got.distance_cm, 0);
         return;
      end
      want = readings_due.pop_front();
      if (got.trigger_out !== want.trigger_out)
         report("trigger_out", got.trigger_out, want.trigger_out);
      if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
      if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
      if (got.fault !== want.fault) report("fault", got.fault, want.fault);
      if (got.distance_cm !== want.distance_cm)
         report("distance_cm", got.distance_cm, want.distance_cm);
      if (got.digit_hundreds !== want.digit_hundreds)
         report("digit_hundreds", got.digit_hundreds, want.digit_hundreds);
      if (got.digit_tens !== want.digit_tens)
         report("digit_tens", got.digit_tens, want.digit_tens);
      if (got.digit_units !== want.digit_units)
         report("digit_units", got.digit_units, want.digit_units);
   endtask

   // Response side: check each accepted response, then stall for a random count.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         check_reading({rsp_chan.trigger_out, rsp_chan.busy_res, rsp_chan.done_res,
                        rsp_chan.fault, rsp_chan.distance_cm, rsp_chan.digit_hundreds,
                        rsp_chan.digit_tens, rsp_chan.digit_units});
         rsp_hold = no_gaps ? 0 : $urandom_range(7);
         rsp_chan.ready <= (rsp_hold == 0);
      end else if (!rsp_chan.ready) begin
         if (rsp_hold <= 1) rsp_chan.ready <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one tick request; the idle gap that follows it is drawn here.
   task automatic send_tick(input bit start, input bit echo, input bit known = 1'b0,
                            input rsp_type reading = '0);
      rsp_type     predicted;
      int unsigned gap;
      req_chan.start_req  <= start;
      req_chan.echo_level <= echo;
      if (!req_up) begin
         req_chan.valid <= 1'b1;
         req_up = 1'b1;
      end
      do @(posedge clock); while (!req_chan.ready);
      predicted = next_reading(start, echo);
      readings_due.push_back(known ? reading : predicted);
      ticks_sent++;
      gap = no_gaps ? 0 : $urandom_range(7);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic lower_req();
      if (req_up) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   task automatic wait_drained();
      lower_req();
      while (readings_due.size() != 0) @(posedge clock);
   endtask

   // Register write, only once every pending reading is back and the pipe is empty.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (index)
         CSR_TIMEOUT: ranger_cfg.timeout_ticks = data;
         CSR_TRIGGER: ranger_cfg.trigger_ticks = data[TRIGGER_W-1:0];
         CSR_SCALE:   ranger_cfg.scale_q16 = data;
         default: ;
      endcase
   endtask

   // Bring the sequencer back to idle by finishing whatever measurement is running.
   task automatic settle();
      while (ranger_phase != PH_IDLE) send_tick(1'b0, ranger_phase == PH_WAIT);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] timeout,
                             input logic [CSR_DATA_W-1:0] trigger,
                             input logic [CSR_DATA_W-1:0] scale);
      settle();
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_TRIGGER, trigger);
      write_reg(CSR_SCALE, scale);
   endtask

   // A well-formed measurement: start, trigger, low echo for a while, then a pulse.
   task automatic measure(input int unsigned wait_len, input int unsigned echo_len);
      settle();
      send_tick(1'b1, 1'($urandom_range(1)));
      while (ranger_phase == PH_TRIG)
         send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int unsigned i = 0; i < wait_len && ranger_phase == PH_WAIT; i++)
         send_tick(1'($urandom_range(1)), 1'b0);
      if (ranger_phase == PH_WAIT) begin
         repeat (echo_len) send_tick(1'($urandom_range(1)), 1'b1);
         send_tick(1'($urandom_range(1)), 1'b0);
      end
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] timeout;
      logic [CSR_DATA_W-1:0] trigger;
      logic [CSR_DATA_W-1:0] scale;
      case ($urandom_range(4))
         0:       timeout = '0;
         1:       timeout = CSR_DATA_W'($urandom_range(1, 8));
         2:       timeout = CSR_DATA_W'($urandom_range(9, 40));
         default: timeout = CSR_DATA_W'($urandom_range(16'hFFFF));
      endcase
      trigger = ($urandom_range(7) == 0) ? CSR_DATA_W'($urandom_range(16'hFFFF))
                                         : CSR_DATA_W'($urandom_range(4));
      case ($urandom_range(3))
         0:       scale = '0;
         1:       scale = 16'hFFFF;
         2:       scale = SCALE_RST;
         default: scale = CSR_DATA_W'($urandom_range(16'hFFFF));
      endcase
      set_config(timeout, trigger, scale);
   endtask

   function automatic void add_tick(input bit start, input bit echo);
      plan.push_back('{ROW_TICK, '0, '0, start, echo, 1'b0, '0});
   endfunction

   function automatic void add_known(input bit start, input bit echo, input rsp_type r);
      plan.push_back('{ROW_TICK, '0, '0, start, echo, 1'b1, r});
   endfunction

   function automatic void add_reg(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
      plan.push_back('{ROW_CSR, index, data, 1'b0, 1'b0, 1'b0, '0});
   endfunction

   initial begin
      int unsigned eff_timeout;
      int unsigned wait_len;
      int unsigned echo_len;

      req_chan.valid      <= 1'b0;
      req_chan.start_req  <= 1'b0;
      req_chan.echo_level <= 1'b0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= '0;
      csr_chan.data       <= '0;
      ranger_cfg      = '{TIMEOUT_RST, TRIGGER_RST, SCALE_RST};
      ranger_phase    = PH_IDLE;
      ranger_ticks    = 0;
      ranger_distance = '0;
      ranger_fault    = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed plan. Idle ticks after reset show all zeros.
      add_known(1'b0, 1'b0, '0);
      add_known(1'b0, 1'b1, '0);
      // An unused index is ignored; zero trigger and timeout act as one.
      add_reg(CSR_UNUSED, 16'hFFFF);
      add_reg(CSR_TRIGGER, 16'hFF00);
      add_reg(CSR_TIMEOUT, 16'h0000);
      add_reg(CSR_SCALE, 16'hFFFF);
      add_known(1'b1, 1'b0, '{1'b1, 1'b1, 1'b0, 1'b0, 11'd0, 4'd0, 4'd0, 4'd0});
      add_known(1'b0, 1'b0, '{1'b0, 1'b0, 1'b1, 1'b1, 11'd0, 4'd0, 4'd0, 4'd0});
      // One-tick echo at full scale truncates to zero distance, a fault.
      add_tick(1'b1, 1'b1);
      add_tick(1'b1, 1'b1);
      add_tick(1'b0, 1'b0);
      // Short timeout after a two-tick trigger.
      add_reg(CSR_TIMEOUT, 16'd3);
      add_reg(CSR_TRIGGER, 16'd2);
      add_reg(CSR_SCALE, 16'd6554);
      add_tick(1'b1, 1'b0);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b0);
      add_tick(1'b0, 1'b0);
      add_tick(1'b0, 1'b0);
      // Start while busy is ignored; a two-tick pulse at full scale gives one cm.
      add_reg(CSR_SCALE, 16'hFFFF);
      add_tick(1'b1, 1'b1);
      add_tick(1'b1, 1'b1);
      add_tick(1'b0, 1'b1);
      add_tick(1'b1, 1'b1);
      add_tick(1'b0, 1'b0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_reg(plan[i].index, plan[i].data);
         else send_tick(plan[i].start, plan[i].echo, plan[i].known, plan[i].reading);
      end

      // Random phases: new registers, then measurements mixed with noise ticks.
      while (ticks_sent < plan.size() + RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(3) == 0);
         random_config();
         eff_timeout = (ranger_cfg.timeout_ticks == 0) ? 1 : ranger_cfg.timeout_ticks;
         for (int k = 0; k < 12 && ticks_sent < plan.size() + RANDOM_ITEMS; k++) begin
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(1, 6))
                  send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
               if (eff_timeout <= 64 && $urandom_range(3) == 0)
                  wait_len = eff_timeout;
               else
                  wait_len = $urandom_range(0, (eff_timeout - 1 < 12) ? eff_timeout - 1 : 12);
               echo_len = ($urandom_range(19) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(1, 40);
               measure(wait_len, echo_len);
            end
         end
      end

      // Long run without gaps: a large three-digit distance at full scale.
      no_gaps = 1'b1;
      set_config(16'd100, 16'd1, 16'hFFFF);
      measure(1, 400);
      no_gaps = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
